FILE: rtl/usbcra_pkg.sv
package usbcra_pkg;

   // alternate setting slots held on chip
   localparam int unsigned INTERFACE_SLOTS = 32;
   localparam int unsigned IFC_W = (INTERFACE_SLOTS > 1) ? $clog2(INTERFACE_SLOTS) : 1;

   // dispositions
   localparam logic [2:0] DISP_LOCAL     = 3'd0;
   localparam logic [2:0] DISP_ABSORB    = 3'd1;
   localparam logic [2:0] DISP_ARBITRATE = 3'd2;
   localparam logic [2:0] DISP_FORWARD   = 3'd3;
   localparam logic [2:0] DISP_STALL     = 3'd4;

   // local reply sources
   localparam logic [2:0] SRC_NONE      = 3'd0;
   localparam logic [2:0] SRC_DEVICE    = 3'd1;
   localparam logic [2:0] SRC_CONFIG    = 3'd2;
   localparam logic [2:0] SRC_STRING    = 3'd3;
   localparam logic [2:0] SRC_BOS       = 3'd4;
   localparam logic [2:0] SRC_QUALIFIER = 3'd5;
   localparam logic [2:0] SRC_OTHER     = 3'd6;
   localparam logic [2:0] SRC_STATE     = 3'd7;

   // arbitrated verbs
   localparam logic [1:0] VERB_NONE       = 2'd0;
   localparam logic [1:0] VERB_SET_CONFIG = 2'd1;
   localparam logic [1:0] VERB_SET_IFC    = 2'd2;
   localparam logic [1:0] VERB_CLEAR_HALT = 2'd3;

   // standard request codes
   localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
   localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
   localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;
   localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
   localparam logic [7:0] REQ_GET_DESC      = 8'd6;
   localparam logic [7:0] REQ_SET_DESC      = 8'd7;
   localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
   localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;
   localparam logic [7:0] REQ_GET_IFC       = 8'd10;
   localparam logic [7:0] REQ_SET_IFC       = 8'd11;
   localparam logic [7:0] REQ_SET_SEL       = 8'd48;
   localparam logic [7:0] REQ_SET_ISOCH     = 8'd49;

   // descriptor types
   localparam logic [7:0] DT_DEVICE    = 8'd1;
   localparam logic [7:0] DT_CONFIG    = 8'd2;
   localparam logic [7:0] DT_STRING    = 8'd3;
   localparam logic [7:0] DT_QUALIFIER = 8'd6;
   localparam logic [7:0] DT_OTHER     = 8'd7;
   localparam logic [7:0] DT_BOS       = 8'd15;

   // feature selectors
   localparam logic [15:0] FEAT_EP_HALT   = 16'd0;
   localparam logic [15:0] FEAT_WAKEUP    = 16'd1;
   localparam logic [15:0] FEAT_TEST_MODE = 16'd2;
   localparam logic [15:0] FEAT_U1        = 16'd48;
   localparam logic [15:0] FEAT_U2        = 16'd49;
   localparam logic [15:0] FEAT_LTM       = 16'd50;

   localparam logic [4:0] RECIP_ENDPOINT = 5'd2;
   localparam logic [1:0] TYPE_STANDARD  = 2'd0;

   typedef struct packed {
      logic        mode;
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] setup_value;
      logic [15:0] setup_index;
      logic [15:0] setup_length;
      logic [1:0]  commit_verb;
      logic [15:0] commit_arg0;
      logic [15:0] commit_arg1;
   } req_type;

   typedef struct packed {
      logic [2:0]  disposition;
      logic [2:0]  local_source;
      logic [7:0]  descriptor_index;
      logic [15:0] language_id;
      logic [7:0]  reply_byte;
      logic [15:0] reply_length;
      logic        reply_short;
      logic [1:0]  verb;
      logic [15:0] verb_arg0;
      logic [15:0] verb_arg1;
      logic [31:0] generation;
   } rsp_type;

   typedef struct packed {
      logic        en;
      logic [1:0]  verb;
      logic [15:0] arg0;
      logic [15:0] arg1;
   } commit_type;

endpackage

FILE: rtl/usbcra_state.sv
module usbcra_state
   import usbcra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  commit_type  commit,
   input  logic [7:0]  rd_ifc,
   output logic [7:0]  cur_config,
   output logic [7:0]  alt_byte,
   output logic [31:0] gen_cur,
   output logic [31:0] gen_next
);

   logic [7:0]  config_ff, config_in;
   logic [7:0]  alt_ff [INTERFACE_SLOTS];
   logic [7:0]  alt_in [INTERFACE_SLOTS];
   logic [31:0] gen_ff, gen_in;
   logic        bump;
   logic        slot_ok;

   assign bump    = commit.en && (commit.verb == VERB_SET_CONFIG || commit.verb == VERB_SET_IFC);
   assign slot_ok = {1'b0, commit.arg0} < 17'(INTERFACE_SLOTS);

   always_comb begin
      config_in = config_ff;
      alt_in    = alt_ff;
      if (commit.en && commit.verb == VERB_SET_CONFIG) begin
         config_in = commit.arg0[7:0];
         for (int i = 0; i < INTERFACE_SLOTS; i++) begin
            alt_in[i] = 8'd0;
         end
      end else if (commit.en && commit.verb == VERB_SET_IFC && slot_ok) begin
         alt_in[commit.arg0[IFC_W-1:0]] = commit.arg1[7:0];
      end
   end

   assign gen_in = bump ? gen_ff + 32'd1 : gen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         config_ff <= 8'd0;
         gen_ff    <= 32'd0;
         for (int i = 0; i < INTERFACE_SLOTS; i++) begin
            alt_ff[i] <= 8'd0;
         end
      end else begin
         config_ff <= config_in;
         gen_ff    <= gen_in;
         alt_ff    <= alt_in;
      end
   end

   // slots past the table read as zero
   always_comb begin
      alt_byte = 8'd0;
      if ({1'b0, rd_ifc} < 9'(INTERFACE_SLOTS)) begin
         alt_byte = alt_ff[rd_ifc[IFC_W-1:0]];
      end
   end

   assign cur_config = config_ff;
   assign gen_cur    = gen_ff;
   assign gen_next   = gen_in;

endmodule

FILE: rtl/usbcra_decode.sv
module usbcra_decode
   import usbcra_pkg::*;
(
   input  req_type     item,
   input  logic [7:0]  cur_config,
   input  logic [7:0]  alt_byte,
   input  logic [31:0] gen_next,
   output rsp_type     result
);

   logic [2:0]  desc_src;
   logic [7:0]  state_byte;
   logic        is_feature_sel;

   always_comb begin
      case (item.setup_value[15:8])
         DT_DEVICE:    desc_src = SRC_DEVICE;
         DT_CONFIG:    desc_src = SRC_CONFIG;
         DT_STRING:    desc_src = SRC_STRING;
         DT_BOS:       desc_src = SRC_BOS;
         DT_QUALIFIER: desc_src = SRC_QUALIFIER;
         DT_OTHER:     desc_src = SRC_OTHER;
         default:      desc_src = SRC_NONE;
      endcase
   end

   assign state_byte = (item.request_code == REQ_GET_CONFIG) ? cur_config : alt_byte;

   // link power and wakeup selectors are absorbed
   assign is_feature_sel = item.setup_value == FEAT_WAKEUP || item.setup_value == FEAT_U1 ||
                           item.setup_value == FEAT_U2 || item.setup_value == FEAT_LTM;

   always_comb begin
      result            = '0;
      result.generation = gen_next;
      if (item.mode) begin
         result.disposition = DISP_LOCAL;
         result.verb        = item.commit_verb;
         result.verb_arg0   = item.commit_arg0;
         result.verb_arg1   = item.commit_arg1;
      end else if (item.request_type[6:5] != TYPE_STANDARD) begin
         result.disposition = DISP_FORWARD;
      end else begin
         case (item.request_code)
            REQ_GET_DESC: begin
               if (desc_src == SRC_NONE) begin
                  result.disposition = DISP_FORWARD;
               end else begin
                  result.disposition      = DISP_LOCAL;
                  result.local_source     = desc_src;
                  result.descriptor_index = item.setup_value[7:0];
                  result.language_id      = (desc_src == SRC_STRING) ? item.setup_index : 16'd0;
                  result.reply_length     = item.setup_length;
               end
            end
            REQ_SET_ADDRESS: begin
               result.disposition = DISP_ABSORB;
            end
            REQ_SET_CONFIG: begin
               result.disposition = DISP_ARBITRATE;
               result.verb        = VERB_SET_CONFIG;
               result.verb_arg0   = {8'd0, item.setup_value[7:0]};
            end
            REQ_SET_IFC: begin
               result.disposition = DISP_ARBITRATE;
               result.verb        = VERB_SET_IFC;
               result.verb_arg0   = item.setup_index;
               result.verb_arg1   = item.setup_value;
            end
            REQ_GET_CONFIG, REQ_GET_IFC: begin
               result.disposition  = DISP_LOCAL;
               result.local_source = SRC_STATE;
               result.reply_byte   = state_byte;
               result.reply_length = {15'd0, item.setup_length != 16'd0};
               result.reply_short  = item.setup_length > 16'd1;
            end
            REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
               if (item.request_code == REQ_CLEAR_FEATURE &&
                   item.request_type[4:0] == RECIP_ENDPOINT &&
                   item.setup_value == FEAT_EP_HALT) begin
                  result.disposition = DISP_ARBITRATE;
                  result.verb        = VERB_CLEAR_HALT;
                  result.verb_arg0   = item.setup_index;
               end else if (is_feature_sel) begin
                  result.disposition = DISP_ABSORB;
               end else if (item.request_code == REQ_SET_FEATURE &&
                            item.setup_value == FEAT_TEST_MODE) begin
                  result.disposition = DISP_STALL;
               end else begin
                  result.disposition = DISP_FORWARD;
               end
            end
            REQ_SET_DESC: begin
               result.disposition = DISP_STALL;
            end
            REQ_SET_SEL, REQ_SET_ISOCH: begin
               result.disposition = DISP_ABSORB;
            end
            default: begin
               result.disposition = DISP_FORWARD;
            end
         endcase
      end
   end

endmodule

FILE: rtl/usb_control_request_arbiter.sv
// channel    | dir | tdata (lsb first)                                     | tuser
// req_       | in  | request_type 8, request_code 8, setup_value 16,       | mode 1
//            |     | setup_index 16, setup_length 16, commit_verb 2,       |
//            |     | commit_arg0 16, commit_arg1 16, zero pad to 104       |
// rsp_       | out | local_source 3, descriptor_index 8, language_id 16,    | disposition 3
//            |     | reply_byte 8, reply_length 16, reply_short 1, verb 2, |
//            |     | verb_arg0 16, verb_arg1 16, generation 32, pad to 120 |
//
// one request per cycle while rsp_tready is high; a response is valid once its register loads
// pipeline: request register, then decode plus state update into the response register
// commits write the stored configuration and alternate settings on the edge that loads
// their response, so the very next request already sees the new state
// reset clears the configuration, all alternate settings and the generation counter
// a stalled response holds the request register; req_tready drops only when both are full
module usb_control_request_arbiter
   import usbcra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // request_type, request_code, setup_value, setup_index,
                                    // setup_length, commit_verb, commit_arg0, commit_arg1
   input  logic [0:0]   req_tuser,  // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,  // local_source, descriptor_index, language_id,
                                    // reply_byte, reply_length, reply_short, verb,
                                    // verb_arg0, verb_arg1, generation
   output logic [2:0]   rsp_tuser   // disposition
);

   // request register
   logic       in_valid_ff, in_valid_in;
   req_type    in_ff, in_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       req_take;
   logic       advance;
   logic       load;

   commit_type commit;
   logic [7:0] cur_config;
   logic [7:0] alt_byte;
   logic [31:0] gen_cur;
   logic [31:0] gen_next;

   // response slot free or being emptied this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign load       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // unpack the request
   always_comb begin
      in_in              = in_ff;
      if (req_take) begin
         in_in.mode         = req_tuser[0];
         in_in.request_type = req_tdata[7:0];
         in_in.request_code = req_tdata[15:8];
         in_in.setup_value  = req_tdata[31:16];
         in_in.setup_index  = req_tdata[47:32];
         in_in.setup_length = req_tdata[63:48];
         in_in.commit_verb  = req_tdata[65:64];
         in_in.commit_arg0  = req_tdata[81:66];
         in_in.commit_arg1  = req_tdata[97:82];
      end
   end

   assign in_valid_in = req_take ? 1'b1 : (load ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   // commits take effect only when their response is loaded
   assign commit.en   = load && in_ff.mode;
   assign commit.verb = in_ff.commit_verb;
   assign commit.arg0 = in_ff.commit_arg0;
   assign commit.arg1 = in_ff.commit_arg1;

   usbcra_state u_state (
      .clock      (clock),
      .reset      (reset),
      .commit     (commit),
      .rd_ifc     (in_ff.setup_index[7:0]),
      .cur_config (cur_config),
      .alt_byte   (alt_byte),
      .gen_cur    (gen_cur),
      .gen_next   (gen_next)
   );

   usbcra_decode u_decode (
      .item       (in_ff),
      .cur_config (cur_config),
      .alt_byte   (alt_byte),
      .gen_next   (gen_next),
      .result     (rsp_in)
   );

   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // pack the response
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.disposition;
   assign rsp_tdata  = {2'd0,
                        rsp_ff.generation,
                        rsp_ff.verb_arg1,
                        rsp_ff.verb_arg0,
                        rsp_ff.verb,
                        rsp_ff.reply_short,
                        rsp_ff.reply_length,
                        rsp_ff.reply_byte,
                        rsp_ff.language_id,
                        rsp_ff.descriptor_index,
                        rsp_ff.local_source};

   // a non-commit request leaves the generation counter alone
   a_gen_hold: assert property (@(posedge clock) disable iff (reset)
      (load && !in_ff.mode) |=> (gen_cur == $past(gen_cur)))
      else $error("generation moved on a setup request");

   // a loaded response carries the counter value the state holds afterwards
   a_gen_match: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_ff.generation == gen_cur))
      else $error("response generation differs from stored counter");

   // verbs only appear on arbitrated requests or commit echoes
   a_verb_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.verb != VERB_NONE) |->
         (rsp_ff.disposition == DISP_ARBITRATE ||
          (rsp_ff.disposition == DISP_LOCAL && rsp_ff.local_source == SRC_NONE)))
      else $error("verb on a non-arbitrated response");

   // a short reply is always a one-byte state reply
   a_short: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.reply_short) |->
         (rsp_ff.local_source == SRC_STATE && rsp_ff.reply_length == 16'd1))
      else $error("short flag on a non state byte reply");

   // back-pressure only when both registers are full and the sink is stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request side stalled without cause");

endmodule

FILE: verif/tb_usb_control_request_arbiter.sv
module tb_usb_control_request_arbiter;
   timeunit 1ns;
   timeprecision 1ps;

   import usbcra_pkg::*;

   localparam int unsigned RANDOM_REQUESTS = 1000;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned DRAIN_CYCLES    = 20;
   localparam int unsigned RESET_CYCLES    = 12;

   // expected-response store with its own copy of the endpoint state
   class request_scoreboard;
      logic [7:0]  cfg_value;
      logic [7:0]  alt_setting [INTERFACE_SLOTS];
      logic [31:0] gen_count;
      rsp_type     pending [$];
      int          errors;
      int          responses;

      function new();
         cfg_value = '0;
         foreach (alt_setting[i]) alt_setting[i] = '0;
         gen_count = '0;
         errors    = 0;
         responses = 0;
      endfunction

      // get-configuration / get-interface reply of one byte
      function automatic void state_byte(ref rsp_type o, input logic [7:0] b,
                                         input logic [15:0] len);
         o.disposition  = DISP_LOCAL;
         o.local_source = SRC_STATE;
         o.reply_byte   = b;
         o.reply_length = (len == 16'd0) ? 16'd0 : 16'd1;
         o.reply_short  = (len > 16'd1);
      endfunction

      function automatic rsp_type decode_request(req_type r);
         rsp_type     o;
         logic [2:0]  src;
         logic [7:0]  ifc;
         logic [15:0] val;
         o   = '0;
         val = r.setup_value;
         if (r.mode) begin
            case (r.commit_verb)
               VERB_SET_CONFIG: begin
                  cfg_value = r.commit_arg0[7:0];
                  foreach (alt_setting[i]) alt_setting[i] = '0;
                  gen_count = gen_count + 1;
               end
               VERB_SET_IFC: begin
                  if (r.commit_arg0 < INTERFACE_SLOTS)
                     alt_setting[r.commit_arg0[IFC_W-1:0]] = r.commit_arg1[7:0];
                  gen_count = gen_count + 1;
               end
               default: ;
            endcase
            o.verb      = r.commit_verb;
            o.verb_arg0 = r.commit_arg0;
            o.verb_arg1 = r.commit_arg1;
         end else if (r.request_type[6:5] != TYPE_STANDARD) begin
            o.disposition = DISP_FORWARD;
         end else begin
            case (r.request_code)
               REQ_GET_DESC: begin
                  case (val[15:8])
                     DT_DEVICE:    src = SRC_DEVICE;
                     DT_CONFIG:    src = SRC_CONFIG;
                     DT_STRING:    src = SRC_STRING;
                     DT_BOS:       src = SRC_BOS;
                     DT_QUALIFIER: src = SRC_QUALIFIER;
                     DT_OTHER:     src = SRC_OTHER;
                     default:      src = SRC_NONE;
                  endcase
                  if (src == SRC_NONE) begin
                     o.disposition = DISP_FORWARD;
                  end else begin
                     o.disposition      = DISP_LOCAL;
                     o.local_source     = src;
                     o.descriptor_index = val[7:0];
                     o.language_id      = (src == SRC_STRING) ? r.setup_index : 16'd0;
                     o.reply_length     = r.setup_length;
                  end
               end
               REQ_SET_ADDRESS: o.disposition = DISP_ABSORB;
               REQ_SET_CONFIG: begin
                  o.disposition = DISP_ARBITRATE;
                  o.verb        = VERB_SET_CONFIG;
                  o.verb_arg0   = {8'd0, val[7:0]};
               end
               REQ_SET_IFC: begin
                  o.disposition = DISP_ARBITRATE;
                  o.verb        = VERB_SET_IFC;
                  o.verb_arg0   = r.setup_index;
                  o.verb_arg1   = val;
               end
               REQ_GET_CONFIG: state_byte(o, cfg_value, r.setup_length);
               REQ_GET_IFC: begin
                  ifc = r.setup_index[7:0];
                  state_byte(o, (ifc < INTERFACE_SLOTS) ? alt_setting[ifc[IFC_W-1:0]] : 8'd0,
                             r.setup_length);
               end
               REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                  if (r.request_code == REQ_CLEAR_FEATURE &&
                      r.request_type[4:0] == RECIP_ENDPOINT && val == FEAT_EP_HALT) begin
                     o.disposition = DISP_ARBITRATE;
                     o.verb        = VERB_CLEAR_HALT;
                     o.verb_arg0   = r.setup_index;
                  end else if (val == FEAT_WAKEUP || val == FEAT_U1 || val == FEAT_U2 ||
                               val == FEAT_LTM) begin
                     o.disposition = DISP_ABSORB;
                  end else if (r.request_code == REQ_SET_FEATURE &&
                               val == FEAT_TEST_MODE) begin
                     o.disposition = DISP_STALL;
                  end else begin
                     o.disposition = DISP_FORWARD;
                  end
               end
               REQ_SET_DESC:               o.disposition = DISP_STALL;
               REQ_SET_SEL, REQ_SET_ISOCH: o.disposition = DISP_ABSORB;
               default:                    o.disposition = DISP_FORWARD;
            endcase
         end
         o.generation = gen_count;
         return o;
      endfunction

      function void note_request(req_type r);
         pending.push_back(decode_request(r));
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 40) $display("mismatch at response %0d: %s", responses, msg);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending.pop_front();
            compare_field("disposition", 32'(got.disposition), 32'(want.disposition));
            compare_field("local_source", 32'(got.local_source), 32'(want.local_source));
            compare_field("descriptor_index", 32'(got.descriptor_index),
                          32'(want.descriptor_index));
            compare_field("language_id", 32'(got.language_id), 32'(want.language_id));
            compare_field("reply_byte", 32'(got.reply_byte), 32'(want.reply_byte));
            compare_field("reply_length", 32'(got.reply_length), 32'(want.reply_length));
            compare_field("reply_short", 32'(got.reply_short), 32'(want.reply_short));
            compare_field("verb", 32'(got.verb), 32'(want.verb));
            compare_field("verb_arg0", 32'(got.verb_arg0), 32'(want.verb_arg0));
            compare_field("verb_arg1", 32'(got.verb_arg1), 32'(want.verb_arg1));
            compare_field("generation", got.generation, want.generation);
         end
         responses++;
      endtask
   endclass

   // clock, reset and all block inputs start at known values
   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic [103:0] req_tdata  = '0;
   logic [0:0]   req_tuser  = '0;
   logic         rsp_tready = 1'b0;
   logic         req_tready;
   logic         rsp_tvalid;
   logic [119:0] rsp_tdata;
   logic [2:0]   rsp_tuser;

   request_scoreboard board;
   int unsigned       cycle_count = 0;
   int unsigned       stall_left  = 0;
   logic              tx_calm     = 1'b0;
   logic              rx_calm     = 1'b0;
   logic              draining    = 1'b0;

   usb_control_request_arbiter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // run limit, far above the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // idle length: mostly none or short, now and then long, nothing in calm stretches
   function automatic int unsigned pick_gap(logic calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm)   return 0;
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // 16-bit value leaning on the extremes
   function automatic logic [15:0] edgy16();
      logic [15:0] v;
      v = 16'($urandom);
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h0001;
         3:       return 16'h0002;
         default: return v;
      endcase
   endfunction

   // every field random; later shaped per request kind
   function automatic req_type noise_request();
      req_type r;
      r.mode         = 1'($urandom);
      r.request_type = 8'($urandom);
      r.request_code = 8'($urandom);
      r.setup_value  = 16'($urandom);
      r.setup_index  = 16'($urandom);
      r.setup_length = 16'($urandom);
      r.commit_verb  = 2'($urandom);
      r.commit_arg0  = 16'($urandom);
      r.commit_arg1  = 16'($urandom);
      return r;
   endfunction

   function automatic req_type make_setup(logic [7:0] rtype, logic [7:0] code,
                                          logic [15:0] val, logic [15:0] idx,
                                          logic [15:0] len);
      req_type r;
      r              = noise_request();
      r.mode         = 1'b0;
      r.request_type = rtype;
      r.request_code = code;
      r.setup_value  = val;
      r.setup_index  = idx;
      r.setup_length = len;
      return r;
   endfunction

   function automatic req_type make_commit(logic [1:0] verb, logic [15:0] a0,
                                           logic [15:0] a1);
      req_type r;
      r             = noise_request();
      r.mode        = 1'b1;
      r.commit_verb = verb;
      r.commit_arg0 = a0;
      r.commit_arg1 = a1;
      return r;
   endfunction

   // mostly well-formed standard requests and commits, some other types and pure noise
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      logic [7:0]  lo;
      logic [7:0]  hi;
      r    = noise_request();
      pick = $urandom_range(0, 99);
      lo   = 8'($urandom);
      hi   = 8'($urandom);
      if (pick < 8) return r;
      if (pick < 38) begin
         r.mode = 1'b1;
         case ($urandom_range(0, 9))
            0:       r.commit_verb = VERB_NONE;
            1:       r.commit_verb = VERB_SET_CONFIG;
            8, 9:    r.commit_verb = VERB_CLEAR_HALT;
            default: r.commit_verb = VERB_SET_IFC;
         endcase
         if (r.commit_verb == VERB_SET_IFC && $urandom_range(0, 4) != 0)
            r.commit_arg0 = 16'($urandom_range(0, INTERFACE_SLOTS + 1));
         return r;
      end
      r.mode = 1'b0;
      if (pick < 43) begin
         // class, vendor or reserved type
         r.request_type[6:5] = 2'($urandom_range(1, 3));
         return r;
      end
      r.request_type[6:5] = TYPE_STANDARD;
      if ($urandom_range(0, 3) != 0) r.request_type[4:0] = 5'($urandom_range(0, 2));
      case ($urandom_range(0, 15))
         0:       r.request_code = REQ_GET_STATUS;
         1, 2:    r.request_code = REQ_CLEAR_FEATURE;
         3, 4:    r.request_code = REQ_SET_FEATURE;
         5:       r.request_code = REQ_SET_ADDRESS;
         6, 7:    r.request_code = REQ_GET_DESC;
         8:       r.request_code = REQ_SET_DESC;
         9:       r.request_code = REQ_GET_CONFIG;
         10:      r.request_code = REQ_SET_CONFIG;
         11, 12:  r.request_code = REQ_GET_IFC;
         13:      r.request_code = REQ_SET_IFC;
         14:      r.request_code = ($urandom_range(0, 1) != 0) ? REQ_SET_SEL : REQ_SET_ISOCH;
         default: r.request_code = 8'($urandom);
      endcase
      if (r.request_code == REQ_GET_DESC) begin
         case ($urandom_range(0, 7))
            0:       hi = DT_DEVICE;
            1:       hi = DT_CONFIG;
            2:       hi = DT_STRING;
            3:       hi = DT_BOS;
            4:       hi = DT_QUALIFIER;
            5:       hi = DT_OTHER;
            default: ;
         endcase
         r.setup_value = {hi, lo};
      end else if (r.request_code == REQ_CLEAR_FEATURE || r.request_code == REQ_SET_FEATURE) begin
         case ($urandom_range(0, 7))
            0, 1:    r.setup_value = FEAT_EP_HALT;
            2:       r.setup_value = FEAT_WAKEUP;
            3:       r.setup_value = FEAT_TEST_MODE;
            4:       r.setup_value = FEAT_U1;
            5:       r.setup_value = FEAT_U2;
            6:       r.setup_value = FEAT_LTM;
            default: ;
         endcase
      end else if (r.request_code == REQ_GET_IFC) begin
         lo            = 8'($urandom_range(0, INTERFACE_SLOTS + 8));
         r.setup_index = {hi, lo};
      end
      r.setup_length = edgy16();
      return r;
   endfunction

   // hold the request until the block takes it, then log it for prediction
   task send_request(req_type r);
      req_tvalid <= 1'b1;
      req_tuser  <= r.mode;
      req_tdata  <= {6'd0, r.commit_arg1, r.commit_arg0, r.commit_verb, r.setup_length,
                     r.setup_index, r.setup_value, r.request_code, r.request_type};
      do @(posedge clock); while (!req_tready);
      board.note_request(r);
   endtask

   // sender-side idle after a taken request
   task sender_idle();
      int unsigned gap;
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side: check whatever the block hands over, then choose next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response({rsp_tuser, rsp_tdata[2:0], rsp_tdata[10:3], rsp_tdata[26:11],
                               rsp_tdata[34:27], rsp_tdata[50:35], rsp_tdata[51],
                               rsp_tdata[53:52], rsp_tdata[69:54], rsp_tdata[85:70],
                               rsp_tdata[117:86]});
      if (cycle_count % 300 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (draining) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left  = stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = pick_gap(rx_calm);
         if (stall_left == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left  = stall_left - 1;
         end
      end
   end

   initial begin
      req_type directed_q [$];
      board = new();

      // descriptor sources, unknown type, length extremes
      directed_q.push_back(make_setup(8'h80, REQ_GET_DESC, {DT_DEVICE, 8'h00}, 16'h0000,
                                      16'hFFFF));
      directed_q.push_back(make_setup(8'h80, REQ_GET_DESC, {DT_CONFIG, 8'hFF}, 16'hFFFF,
                                      16'h0000));
      directed_q.push_back(make_setup(8'h80, REQ_GET_DESC, {DT_STRING, 8'h02}, 16'h0409,
                                      16'h00FF));
      directed_q.push_back(make_setup(8'h80, REQ_GET_DESC, {DT_BOS, 8'h00}, 16'h1234, 16'd5));
      directed_q.push_back(make_setup(8'h80, REQ_GET_DESC, {DT_QUALIFIER, 8'h01}, 16'd0,
                                      16'd10));
      directed_q.push_back(make_setup(8'h80, REQ_GET_DESC, {DT_OTHER, 8'h00}, 16'd0, 16'd9));
      directed_q.push_back(make_setup(8'h80, REQ_GET_DESC, 16'hFF01, 16'd0, 16'd64));
      // address, arbitrated set-config and set-interface
      directed_q.push_back(make_setup(8'h00, REQ_SET_ADDRESS, 16'h007F, 16'd0, 16'd0));
      directed_q.push_back(make_setup(8'h00, REQ_SET_CONFIG, 16'hAB12, 16'd0, 16'd0));
      directed_q.push_back(make_setup(8'h01, REQ_SET_IFC, 16'hFFFF, 16'h8001, 16'd0));
      // commits: config clears alternates, in-range and out-of-range interface, no-ops
      directed_q.push_back(make_commit(VERB_SET_CONFIG, 16'hFF03, 16'hFFFF));
      directed_q.push_back(make_commit(VERB_SET_IFC, 16'd5, 16'h12FF));
      directed_q.push_back(make_commit(VERB_SET_IFC, 16'hFFFF, 16'h00AA));
      directed_q.push_back(make_commit(VERB_NONE, 16'hFFFF, 16'hFFFF));
      directed_q.push_back(make_commit(VERB_CLEAR_HALT, 16'h0081, 16'd0));
      // state byte replies: zero length, short reply, interface beyond the slots
      directed_q.push_back(make_setup(8'h80, REQ_GET_CONFIG, 16'd0, 16'd0, 16'd0));
      directed_q.push_back(make_setup(8'h80, REQ_GET_CONFIG, 16'd0, 16'd0, 16'hFFFF));
      directed_q.push_back(make_setup(8'h81, REQ_GET_IFC, 16'd0, 16'hFF05, 16'd1));
      directed_q.push_back(make_setup(8'h81, REQ_GET_IFC, 16'd0, 16'h0020, 16'd2));
      // status and features: endpoint halt, test mode both ways, link power
      directed_q.push_back(make_setup(8'h80, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2));
      directed_q.push_back(make_setup(8'h02, REQ_CLEAR_FEATURE, FEAT_EP_HALT, 16'h0081,
                                      16'd0));
      directed_q.push_back(make_setup(8'h00, REQ_CLEAR_FEATURE, FEAT_TEST_MODE, 16'd0,
                                      16'd0));
      directed_q.push_back(make_setup(8'h00, REQ_SET_FEATURE, FEAT_TEST_MODE, 16'h0400,
                                      16'd0));
      directed_q.push_back(make_setup(8'h00, REQ_SET_FEATURE, FEAT_U1, 16'd0, 16'd0));
      directed_q.push_back(make_setup(8'h00, REQ_SET_DESC, 16'h0100, 16'd0, 16'd18));
      // class request that looks like a standard descriptor read
      directed_q.push_back(make_setup(8'hA1, REQ_GET_DESC, {DT_DEVICE, 8'h00}, 16'd0,
                                      16'd18));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[i]) begin
         send_request(directed_q[i]);
         sender_idle();
      end

      for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 100 == 0) tx_calm = ($urandom_range(0, 3) == 0);
         send_request(random_request());
         sender_idle();
      end
      req_tvalid <= 1'b0;
      draining   <= 1'b1;

      // wait out every outstanding response, then watch for strays
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
